/* src/sbd_pkg.sv */
`default_nettype none
package sbd_pkg;
  localparam int CoordW      = 24;
  localparam int TFracW      = 16;
  localparam int DistW       = 50;
  localparam int NumAxes     = 3;
  localparam int NumCross    = 2 * NumAxes;
  localparam int NumCand     = NumCross + 2;
  localparam int DivStages   = TFracW;
  localparam int PointStages = 8;

  typedef logic signed [CoordW-1:0]        coord_t;
  typedef logic signed [CoordW:0]          diff_t;
  typedef logic        [CoordW-1:0]        mag_t;
  typedef logic        [TFracW-1:0]        frac_t;
  typedef logic signed [CoordW+TFracW+1:0] prod_t;
  typedef logic signed [CoordW+1:0]        point_t;
  typedef logic        [CoordW+1:0]        delta_t;
  typedef logic        [2*CoordW+3:0]      sq_t;
  typedef logic        [2*CoordW+5:0]      sum_t;
  typedef logic        [DistW-1:0]         dist_t;

  localparam dist_t DistMax = '1;

  typedef struct packed {
    coord_t [NumAxes-1:0] s;
    coord_t [NumAxes-1:0] e;
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
  } seg_t;

  typedef struct packed {
    seg_t                seg;
    diff_t [NumAxes-1:0] d;
  } geom_t;

  typedef struct packed {
    logic  [NumCross-1:0] hit;
    mag_t  [NumCross-1:0] num;
    mag_t  [NumCross-1:0] den;
  } cross_t;
endpackage
`default_nettype wire

/* src/sbd_in_if.sv */
`default_nettype none
interface sbd_in_if;
  import sbd_pkg::*;
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t stop_x;
  coord_t stop_y;
  coord_t stop_z;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
    output box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, start_z, stop_x, stop_y, stop_z,
    input  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface
`default_nettype wire

/* src/sbd_out_if.sv */
`default_nettype none
interface sbd_out_if;
  import sbd_pkg::*;
  logic  valid;
  logic  ready;
  dist_t sq_dist;

  modport source (output valid, sq_dist, input ready);
  modport sink (input valid, sq_dist, output ready);
endinterface
`default_nettype wire

/* src/sbd_prep.sv */
`default_nettype none
module sbd_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbd_pkg::seg_t  in_seg,
  output logic           out_valid,
  input  logic           out_ready,
  output sbd_pkg::geom_t out_geom,
  output sbd_pkg::cross_t out_cross
);
  import sbd_pkg::*;

  geom_t  geom_next;
  cross_t cross_next;

  always_comb begin
    coord_t plane;
    coord_t sa;
    diff_t  n;
    diff_t  dv;
    mag_t   an;
    mag_t   ad;
    int     ax;
    geom_next.seg = in_seg;
    for (int a = 0; a < NumAxes; a++) begin
      geom_next.d[a] = {in_seg.e[a][CoordW-1], in_seg.e[a]}
                     - {in_seg.s[a][CoordW-1], in_seg.s[a]};
    end
    for (int c = 0; c < NumCross; c++) begin
      ax    = c >> 1;
      plane = c[0] ? in_seg.hi[ax] : in_seg.lo[ax];
      sa    = in_seg.s[ax];
      n     = {plane[CoordW-1], plane} - {sa[CoordW-1], sa};
      dv    = geom_next.d[ax];
      an    = n[CoordW]  ? mag_t'(-n)  : mag_t'(n);
      ad    = dv[CoordW] ? mag_t'(-dv) : mag_t'(dv);
      cross_next.hit[c] = (dv != '0) && (n != '0) && (n[CoordW] == dv[CoordW]) && (an < ad);
      cross_next.num[c] = an;
      cross_next.den[c] = ad;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_geom  <= geom_next;
      out_cross <= cross_next;
    end
  end
endmodule
`default_nettype wire

/* src/sbd_div.sv */
`default_nettype none
module sbd_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbd_pkg::geom_t in_geom,
  input  sbd_pkg::cross_t in_cross,
  output logic           out_valid,
  input  logic           out_ready,
  output sbd_pkg::geom_t out_geom,
  output logic [sbd_pkg::NumCross-1:0] out_hit,
  output sbd_pkg::frac_t [sbd_pkg::NumCross-1:0] out_t
);
  import sbd_pkg::*;

  logic                 v     [DivStages];
  logic [DivStages-1:0] en;
  geom_t                geom_q[DivStages];
  logic [NumCross-1:0]  hit_q [DivStages];
  mag_t [NumCross-1:0]  den_q [DivStages];
  mag_t [NumCross-1:0]  rem_q [DivStages];
  frac_t [NumCross-1:0] quo_q [DivStages];

  always_comb begin
    en[DivStages-1] = !v[DivStages-1] || out_ready;
    for (int k = DivStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // one quotient bit per stage, restoring
  for (genvar k = 0; k < DivStages; k++) begin : g_stage
    logic                 v_in;
    geom_t                g_in;
    logic [NumCross-1:0]  h_in;
    mag_t [NumCross-1:0]  d_in;
    mag_t [NumCross-1:0]  r_in;
    frac_t [NumCross-1:0] q_in;
    mag_t [NumCross-1:0]  r_nx;
    frac_t [NumCross-1:0] q_nx;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign g_in = in_geom;
      assign h_in = in_cross.hit;
      assign d_in = in_cross.den;
      assign r_in = in_cross.num;
      assign q_in = '0;
    end else begin : g_rest
      assign v_in = v[k-1];
      assign g_in = geom_q[k-1];
      assign h_in = hit_q[k-1];
      assign d_in = den_q[k-1];
      assign r_in = rem_q[k-1];
      assign q_in = quo_q[k-1];
    end

    always_comb begin
      logic [CoordW:0] rem2;
      logic [CoordW:0] den2;
      for (int c = 0; c < NumCross; c++) begin
        rem2 = {r_in[c], 1'b0};
        den2 = {1'b0, d_in[c]};
        if (rem2 >= den2) begin
          r_nx[c] = mag_t'(rem2 - den2);
          q_nx[c] = {q_in[c][TFracW-2:0], 1'b1};
        end else begin
          r_nx[c] = mag_t'(rem2);
          q_nx[c] = {q_in[c][TFracW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_in;
      end
      if (en[k] && v_in) begin
        geom_q[k] <= g_in;
        hit_q[k]  <= h_in;
        den_q[k]  <= d_in;
        rem_q[k]  <= r_nx;
        quo_q[k]  <= q_nx;
      end
    end
  end

  assign out_valid = v[DivStages-1];
  assign out_geom  = geom_q[DivStages-1];
  assign out_hit   = hit_q[DivStages-1];
  assign out_t     = quo_q[DivStages-1];
endmodule
`default_nettype wire

/* src/sbd_point.sv */
`default_nettype none
module sbd_point (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sbd_pkg::geom_t in_geom,
  input  logic [sbd_pkg::NumCross-1:0] in_hit,
  input  sbd_pkg::frac_t [sbd_pkg::NumCross-1:0] in_t,
  output logic           out_valid,
  input  logic           out_ready,
  output sbd_pkg::dist_t out_dist
);
  import sbd_pkg::*;

  logic                   v [PointStages];
  logic [PointStages-1:0] en;

  // stage 0: products
  prod_t  [NumCross-1:0][NumAxes-1:0] prod_q;
  seg_t                               seg0_q;
  logic   [NumCross-1:0]              hit0_q;
  // stage 1: candidate points
  point_t [NumCand-1:0][NumAxes-1:0]  pt_q;
  coord_t [NumAxes-1:0]               lo1_q, hi1_q;
  logic   [NumCand-1:0]               use1_q;
  // stage 2: per-axis excess
  delta_t [NumCand-1:0][NumAxes-1:0]  dl_q;
  logic   [NumCand-1:0]               use2_q;
  // stage 3: squares
  sq_t    [NumCand-1:0][NumAxes-1:0]  sq_q;
  logic   [NumCand-1:0]               use3_q;
  // stage 4..7: distances and min tree
  dist_t  [NumCand-1:0]               cd_q;
  dist_t  [NumCand/2-1:0]             m4_q;
  dist_t  [NumCand/4-1:0]             m2_q;
  dist_t                              m1_q;

  always_comb begin
    en[PointStages-1] = !v[PointStages-1] || out_ready;
    for (int k = PointStages - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < PointStages; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < PointStages; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 0
  prod_t [NumCross-1:0][NumAxes-1:0] prod_nx;
  always_comb begin
    diff_t dk;
    for (int c = 0; c < NumCross; c++) begin
      for (int k = 0; k < NumAxes; k++) begin
        dk = in_geom.d[k];
        prod_nx[c][k] = dk * $signed({1'b0, in_t[c]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0] && in_valid) begin
      prod_q <= prod_nx;
      seg0_q <= in_geom.seg;
      hit0_q <= in_hit;
    end
  end

  // stage 1
  point_t [NumCand-1:0][NumAxes-1:0] pt_nx;
  always_comb begin
    coord_t sk;
    coord_t ek;
    prod_t  pr;
    point_t sh;
    for (int k = 0; k < NumAxes; k++) begin
      sk = seg0_q.s[k];
      ek = seg0_q.e[k];
      for (int c = 0; c < NumCross; c++) begin
        pr = prod_q[c][k];
        sh = point_t'(pr >>> TFracW);
        pt_nx[c][k] = point_t'(sk) + sh;
      end
      pt_nx[NumCross][k]   = point_t'(sk);
      pt_nx[NumCross+1][k] = point_t'(ek);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1] && v[0]) begin
      pt_q   <= pt_nx;
      lo1_q  <= seg0_q.lo;
      hi1_q  <= seg0_q.hi;
      use1_q <= {2'b11, hit0_q};
    end
  end

  // stage 2
  delta_t [NumCand-1:0][NumAxes-1:0] dl_nx;
  always_comb begin
    point_t p;
    point_t lo;
    point_t hi;
    coord_t lc;
    coord_t hc;
    for (int k = 0; k < NumAxes; k++) begin
      lc = lo1_q[k];
      hc = hi1_q[k];
      lo = point_t'(lc);
      hi = point_t'(hc);
      for (int c = 0; c < NumCand; c++) begin
        p = pt_q[c][k];
        if (p < lo) begin
          dl_nx[c][k] = delta_t'(lo - p);
        end else if (p > hi) begin
          dl_nx[c][k] = delta_t'(p - hi);
        end else begin
          dl_nx[c][k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2] && v[1]) begin
      dl_q   <= dl_nx;
      use2_q <= use1_q;
    end
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (en[3] && v[2]) begin
      for (int c = 0; c < NumCand; c++) begin
        for (int k = 0; k < NumAxes; k++) begin
          sq_q[c][k] <= sq_t'(dl_q[c][k]) * sq_t'(dl_q[c][k]);
        end
      end
      use3_q <= use2_q;
    end
  end

  // stage 4
  dist_t [NumCand-1:0] cd_nx;
  always_comb begin
    sum_t sum;
    for (int c = 0; c < NumCand; c++) begin
      sum = sum_t'(sq_q[c][0]) + sum_t'(sq_q[c][1]) + sum_t'(sq_q[c][2]);
      if (!use3_q[c] || sum > sum_t'(DistMax)) begin
        cd_nx[c] = DistMax;
      end else begin
        cd_nx[c] = dist_t'(sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[4] && v[3]) begin
      cd_q <= cd_nx;
    end
    if (en[5] && v[4]) begin
      for (int i = 0; i < NumCand / 2; i++) begin
        m4_q[i] <= (cd_q[2*i+1] < cd_q[2*i]) ? cd_q[2*i+1] : cd_q[2*i];
      end
    end
    if (en[6] && v[5]) begin
      for (int i = 0; i < NumCand / 4; i++) begin
        m2_q[i] <= (m4_q[2*i+1] < m4_q[2*i]) ? m4_q[2*i+1] : m4_q[2*i];
      end
    end
    if (en[7] && v[6]) begin
      m1_q <= (m2_q[1] < m2_q[0]) ? m2_q[1] : m2_q[0];
    end
  end

  assign out_valid = v[PointStages-1];
  assign out_dist  = m1_q;
endmodule
`default_nettype wire

/* src/segment_box_distance_sq_top.sv */
// Segment to axis-aligned box squared distance, streaming.
// req carries one beat per query: segment start/stop and box min/max corners,
// each a signed Q8.16 coordinate. rsp returns one beat per query: sq_dist,
// unsigned Q18.32, the least point-to-box squared distance over the segment
// ends and the segment's crossings of the six box planes.
// Both channels use valid/ready; a beat moves when both are high.
// 25 register stages: one setup stage, a 16-stage radix-2 divider (one bit
// of each crossing parameter per stage), and eight stages for points,
// squares, sums and the min tree. Throughput is one query per cycle while
// rsp is not stalled; the divider stages set the depth.
// Each stage has its own valid bit and loads when it is empty or its
// successor moves, so bubbles close up and new queries enter while a result
// waits on a stalled rsp. A stall holds every beat in place; nothing is
// dropped or repeated. Synchronous reset clears all valid bits; the block
// keeps no other state.
`default_nettype none
module segment_box_distance_sq_top (
  input logic      clk,
  input logic      rst,
  sbd_in_if.sink   req,
  sbd_out_if.source rsp
);
  import sbd_pkg::*;

  seg_t                seg;
  logic                p_valid, p_ready;
  geom_t               p_geom;
  cross_t              p_cross;
  logic                d_valid, d_ready;
  geom_t               d_geom;
  logic [NumCross-1:0] d_hit;
  frac_t [NumCross-1:0] d_t;

  assign seg.s  = {req.start_z, req.start_y, req.start_x};
  assign seg.e  = {req.stop_z, req.stop_y, req.stop_x};
  assign seg.lo = {req.box_min_z, req.box_min_y, req.box_min_x};
  assign seg.hi = {req.box_max_z, req.box_max_y, req.box_max_x};

  sbd_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .in_seg    (seg),
    .out_valid (p_valid),
    .out_ready (p_ready),
    .out_geom  (p_geom),
    .out_cross (p_cross)
  );

  sbd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_valid),
    .in_ready  (p_ready),
    .in_geom   (p_geom),
    .in_cross  (p_cross),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_geom  (d_geom),
    .out_hit   (d_hit),
    .out_t     (d_t)
  );

  sbd_point u_point (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_geom   (d_geom),
    .in_hit    (d_hit),
    .in_t      (d_t),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .out_dist  (rsp.sq_dist)
  );
endmodule
`default_nettype wire

/* test/tb_segment_box_distance_sq_top.sv */
`timescale 1ns / 1ps
module tb_segment_box_distance_sq_top;
  import sbd_pkg::*;

  typedef struct {
    coord_t s[3];
    coord_t e[3];
    coord_t lo[3];
    coord_t hi[3];
  } query_t;

  localparam int unsigned WatchLimit = 20000;
  localparam int HoldCycles = 200;
  localparam longint unsigned DistSat = (64'd1 << DistW) - 1;

  logic clk;
  logic rst;

  sbd_in_if  req ();
  sbd_out_if rsp ();

  segment_box_distance_sq_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  query_t pending_q[$];
  logic [DistW-1:0] expected_dist_q[$];
  int errors = 0;
  bit calm = 0;
  bit hold_rsp = 0;
  bit hold_done = 0;
  int hold_cnt = 0;
  bit in_fire = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned axis_dist(longint p, longint lo, longint hi);
    longint unsigned dlt;
    dlt = 0;
    if (p < lo) dlt = lo - p;
    else if (p > hi) dlt = p - hi;
    if (dlt > 64'hFFFF_FFFF) return DistSat;
    return dlt * dlt;
  endfunction

  function automatic longint unsigned point_dist(longint p[3], longint lo[3], longint hi[3]);
    longint unsigned sum, sq;
    sum = 0;
    for (int a = 0; a < 3; a++) begin
      sq = axis_dist(p[a], lo[a], hi[a]);
      sum = sum + sq;
      if (sum < sq || sum > DistSat) sum = DistSat;
    end
    return sum;
  endfunction

  function automatic longint floor_q16(longint x);
    return x >>> TFracW;
  endfunction

  function automatic logic [DistW-1:0] seg_box_dist(query_t q);
    longint s[3], e[3], lo[3], hi[3], d[3], p[3];
    longint n;
    longint unsigned best, cand, an, ad, t;
    for (int a = 0; a < 3; a++) begin
      s[a] = q.s[a]; e[a] = q.e[a]; lo[a] = q.lo[a]; hi[a] = q.hi[a];
      d[a] = e[a] - s[a];
    end
    best = point_dist(s, lo, hi);
    cand = point_dist(e, lo, hi);
    if (cand < best) best = cand;
    for (int a = 0; a < 3; a++) begin
      if (d[a] != 0) begin
        for (int side = 0; side < 2; side++) begin
          n = (side == 0 ? lo[a] : hi[a]) - s[a];
          if (n != 0 && ((n < 0) == (d[a] < 0))) begin
            an = n < 0 ? -n : n;
            ad = d[a] < 0 ? -d[a] : d[a];
            if (an < ad) begin
              t = (an << TFracW) / ad;
              for (int k = 0; k < 3; k++) p[k] = s[k] + floor_q16(d[k] * longint'(t));
              cand = point_dist(p, lo, hi);
              if (cand < best) best = cand;
            end
          end
        end
      end
    end
    return best[DistW-1:0];
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 2000) - 1000) <<< 16;
      2: return coord_t'(int'($urandom_range(0, 400)) - 200);
      default: return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    coord_t x, y;
    mode = $urandom_range(0, 3);
    for (int a = 0; a < 3; a++) begin
      q.s[a] = rand_coord(mode);
      q.e[a] = ($urandom_range(0, 7) == 0) ? q.s[a] : rand_coord(mode);
      x = rand_coord(mode);
      y = rand_coord(mode);
      if ($urandom_range(0, 9) != 0 && x > y) begin
        q.lo[a] = y; q.hi[a] = x;
      end else begin
        q.lo[a] = x; q.hi[a] = y;
      end
      if ($urandom_range(0, 15) == 0) q.lo[a] = q.s[a];
    end
    return q;
  endfunction

  function automatic query_t fill_query(coord_t s, coord_t e, coord_t lo, coord_t hi);
    query_t q;
    for (int a = 0; a < 3; a++) begin
      q.s[a] = s; q.e[a] = e; q.lo[a] = lo; q.hi[a] = hi;
    end
    return q;
  endfunction

  task automatic queue_query(query_t q);
    pending_q.insert(pending_q.size(), q);
  endtask

  task automatic settle();
    while (pending_q.size() != 0 || expected_dist_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    query_t q;
    coord_t mn, mx;
    mn = {1'b1, {(CoordW-1){1'b0}}};
    mx = {1'b0, {(CoordW-1){1'b1}}};
    rst = 1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;
    queue_query(fill_query(mn, mn, mx, mx));
    queue_query(fill_query(mx, mx, mn, mn));
    queue_query(fill_query(mn, mx, coord_t'(0), coord_t'(0)));
    queue_query(fill_query(mx, mn, coord_t'(-5), coord_t'(5)));
    queue_query(fill_query(mn, mx, mn, mx));
    queue_query(fill_query(coord_t'(0), coord_t'(0), coord_t'(100), coord_t'(200)));
    queue_query(fill_query(coord_t'(-1), coord_t'(-1), coord_t'(0), coord_t'(-1)));
    queue_query(fill_query(mn, mn, mn, mn));
    q = fill_query(coord_t'(0), 24'sh10000, 24'sh4000, 24'sh8000);
    q.s[1] = 24'sh50000; q.e[1] = 24'sh50000;
    queue_query(q);
    q = fill_query(24'sh30000, coord_t'(0), 24'sh10000, 24'sh20000);
    q.e[2] = 24'sh7FFFFF;
    queue_query(q);
    q = fill_query(coord_t'(0), coord_t'(3), coord_t'(3), coord_t'(1));
    queue_query(q);
    q = fill_query(coord_t'(0), coord_t'(3), coord_t'(0), coord_t'(2));
    queue_query(q);
    for (int i = 0; i < 6; i++) queue_query(rand_query());
    settle();
    repeat (40) @(posedge clk);
    for (int i = 0; i < 500; i++) queue_query(rand_query());
    hold_rsp = 1;
    settle();
    for (int i = 0; i < 1232; i++) queue_query(rand_query());
    while (pending_q.size() > 250) @(posedge clk);
    calm = 1;
    settle();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      {req.start_x, req.start_y, req.start_z, req.stop_x, req.stop_y, req.stop_z} <= '0;
      {req.box_min_x, req.box_min_y, req.box_min_z} <= '0;
      {req.box_max_x, req.box_max_y, req.box_max_z} <= '0;
    end else if (req.valid && !in_fire) begin
    end else begin
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (send_gap == 0 && pending_q.size() != 0 &&
          (calm || $urandom_range(0, 7) != 0)) begin
        req.valid <= 1'b1;
        {req.start_x, req.start_y, req.start_z} <=
          {pending_q[0].s[0], pending_q[0].s[1], pending_q[0].s[2]};
        {req.stop_x, req.stop_y, req.stop_z} <=
          {pending_q[0].e[0], pending_q[0].e[1], pending_q[0].e[2]};
        {req.box_min_x, req.box_min_y, req.box_min_z} <=
          {pending_q[0].lo[0], pending_q[0].lo[1], pending_q[0].lo[2]};
        {req.box_max_x, req.box_max_y, req.box_max_z} <=
          {pending_q[0].hi[0], pending_q[0].hi[1], pending_q[0].hi[2]};
      end else begin
        req.valid <= 1'b0;
        if (send_gap == 0 && !calm && $urandom_range(0, 3) == 0)
          send_gap <= $urandom_range(1, 10);
      end
    end
  end

  int rsp_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_rsp && !hold_done) begin
      rsp.ready <= 1'b0;
      if (hold_cnt == HoldCycles - 1) hold_done <= 1'b1;
      hold_cnt <= hold_cnt + 1;
    end else if (rsp_gap > 0) begin
      rsp.ready <= 1'b0;
      rsp_gap <= rsp_gap - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      rsp.ready <= 1'b0;
      rsp_gap <= $urandom_range(0, 9);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // beat capture and check
  always @(posedge clk) begin
    query_t q;
    logic [DistW-1:0] want;
    if (!rst) begin
      in_fire <= req.valid && req.ready;
      if (req.valid && req.ready) begin
        q = pending_q.pop_front();
        expected_dist_q.insert(expected_dist_q.size(), seg_box_dist(q));
      end
      if (rsp.valid && rsp.ready) begin
        if (expected_dist_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, got %0d", $time, rsp.sq_dist);
        end else begin
          want = expected_dist_q.pop_front();
          if (rsp.sq_dist !== want) begin
            errors++;
            $display("%0t: sq_dist expected %0d got %0d", $time, want,
                     rsp.sq_dist);
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (pending_q.size() == 0 && expected_dist_q.size() == 0) ||
          (hold_rsp && !hold_done))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end
endmodule
